FILE: src/mrfb_pkg.sv
package mrfb_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W = $clog2(FRAME_BYTES);

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  localparam logic [IDX_W-1:0] BYTE_DEVICE = 3'd0;
  localparam logic [IDX_W-1:0] BYTE_FUNCTION = 3'd1;
  localparam logic [IDX_W-1:0] BYTE_REG_HI = 3'd2;
  localparam logic [IDX_W-1:0] BYTE_REG_LO = 3'd3;
  localparam logic [IDX_W-1:0] BYTE_VAL_HI = 3'd4;
  localparam logic [IDX_W-1:0] BYTE_VAL_LO = 3'd5;
  localparam logic [IDX_W-1:0] BYTE_CRC_FIRST = 3'd6;
  localparam logic [IDX_W-1:0] BYTE_CRC_SECOND = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic is_check;
    logic ok;
    logic [7:0] device_address;
    logic [7:0] function_number;
    logic [15:0] register_address;
    logic [15:0] register_value;
  } entry_t;

  typedef struct packed {
    logic valid;
    entry_t entry;
  } queue_port_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/mrfb_cmd_if.sv
interface mrfb_cmd_if;
  logic valid;
  logic ready;
  logic command;
  logic [7:0] device_address;
  logic [7:0] function_number;
  logic [15:0] register_address;
  logic [15:0] register_value;
  logic [7:0] reply_byte;

  modport source (
    output valid, command, device_address, function_number,
    output register_address, register_value, reply_byte,
    input ready
  );

  modport sink (
    input valid, command, device_address, function_number,
    input register_address, register_value, reply_byte,
    output ready
  );
endinterface

FILE: src/mrfb_res_if.sv
interface mrfb_res_if;
  logic valid;
  logic ready;
  logic is_check_result;
  logic [7:0] send_byte;
  logic last_of_frame;
  logic crc_ok;
  logic [15:0] reading;

  modport source (
    output valid, is_check_result, send_byte, last_of_frame, crc_ok, reading,
    input ready
  );

  modport sink (
    input valid, is_check_result, send_byte, last_of_frame, crc_ok, reading,
    output ready
  );
endinterface

FILE: src/mrfb_front.sv
module mrfb_front (
  input  logic clk,
  input  logic rst,
  input  logic low_first,
  mrfb_cmd_if.sink cmd,
  input  logic full,
  output mrfb_pkg::queue_port_t push
);

  logic [mrfb_pkg::IDX_W-1:0] reply_count;
  logic [15:0] reply_crc;
  logic [7:0] reply_crc_first_byte;
  logic [15:0] reply_data;

  logic accept;
  logic is_send;
  logic is_last_reply;
  logic [7:0] want_first;
  logic [7:0] want_second;

  assign cmd.ready = !full;
  assign accept = cmd.valid && cmd.ready;
  assign is_send = (cmd.command == mrfb_pkg::CMD_SEND);
  assign is_last_reply = (reply_count == mrfb_pkg::BYTE_CRC_SECOND);

  assign want_first = low_first ? reply_crc[7:0] : reply_crc[15:8];
  assign want_second = low_first ? reply_crc[15:8] : reply_crc[7:0];

  always_comb begin
    push.valid = accept && (is_send || is_last_reply);
    push.entry.is_check = !is_send;
    push.entry.ok = (reply_crc_first_byte == want_first) && (cmd.reply_byte == want_second);
    push.entry.device_address = cmd.device_address;
    push.entry.function_number = cmd.function_number;
    push.entry.register_address = cmd.register_address;
    push.entry.register_value = is_send ? cmd.register_value : reply_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count <= '0;
      reply_crc <= mrfb_pkg::CRC_INIT;
    end else if (accept) begin
      if (is_send || is_last_reply) begin
        reply_count <= '0;
        reply_crc <= mrfb_pkg::CRC_INIT;
      end else begin
        reply_count <= reply_count + 1'b1;
        if (reply_count != mrfb_pkg::BYTE_CRC_FIRST) begin
          reply_crc <= mrfb_pkg::crc_feed(reply_crc, cmd.reply_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_send) begin
      if (reply_count == mrfb_pkg::BYTE_VAL_HI) begin
        reply_data[15:8] <= cmd.reply_byte;
      end
      if (reply_count == mrfb_pkg::BYTE_VAL_LO) begin
        reply_data[7:0] <= cmd.reply_byte;
      end
      if (reply_count == mrfb_pkg::BYTE_CRC_FIRST) begin
        reply_crc_first_byte <= cmd.reply_byte;
      end
    end
  end

endmodule

FILE: src/mrfb_queue.sv
module mrfb_queue (
  input  logic clk,
  input  logic rst,
  input  mrfb_pkg::queue_port_t push,
  output logic full,
  output mrfb_pkg::queue_port_t head,
  input  logic pop
);

  mrfb_pkg::entry_t slots [mrfb_pkg::QUEUE_DEPTH];
  logic [mrfb_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [mrfb_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [mrfb_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == mrfb_pkg::QUEUE_CNT_W'(mrfb_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mrfb_pkg::QUEUE_PTR_W'(mrfb_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mrfb_pkg::QUEUE_PTR_W'(mrfb_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

FILE: src/mrfb_back.sv
module mrfb_back (
  input  logic clk,
  input  logic rst,
  input  logic low_first,
  input  mrfb_pkg::queue_port_t head,
  output logic pop,
  mrfb_res_if.source res
);

  logic active;
  mrfb_pkg::entry_t cur;
  logic [mrfb_pkg::IDX_W-1:0] idx;
  logic [15:0] crc;

  logic out_valid;
  logic out_is_check;
  logic [7:0] out_byte;
  logic out_last;
  logic out_ok;
  logic [15:0] out_reading;

  logic advance;
  logic finishing;
  logic [7:0] cur_byte;
  logic [7:0] crc_first;
  logic [7:0] crc_second;

  assign crc_first = low_first ? crc[7:0] : crc[15:8];
  assign crc_second = low_first ? crc[15:8] : crc[7:0];

  always_comb begin
    unique case (idx)
      mrfb_pkg::BYTE_DEVICE: cur_byte = cur.device_address;
      mrfb_pkg::BYTE_FUNCTION: cur_byte = cur.function_number;
      mrfb_pkg::BYTE_REG_HI: cur_byte = cur.register_address[15:8];
      mrfb_pkg::BYTE_REG_LO: cur_byte = cur.register_address[7:0];
      mrfb_pkg::BYTE_VAL_HI: cur_byte = cur.register_value[15:8];
      mrfb_pkg::BYTE_VAL_LO: cur_byte = cur.register_value[7:0];
      mrfb_pkg::BYTE_CRC_FIRST: cur_byte = crc_first;
      mrfb_pkg::BYTE_CRC_SECOND: cur_byte = crc_second;
      default: cur_byte = '0;
    endcase
  end

  assign advance = !out_valid || res.ready;
  assign finishing = cur.is_check || (idx == mrfb_pkg::BYTE_CRC_SECOND);
  assign pop = head.valid && (!active || (advance && finishing));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (advance && active && finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.entry;
      idx <= '0;
      crc <= mrfb_pkg::CRC_INIT;
    end else if (advance && active && !finishing) begin
      idx <= idx + 1'b1;
      if (idx < mrfb_pkg::BYTE_CRC_FIRST) begin
        crc <= mrfb_pkg::crc_feed(crc, cur_byte);
      end
    end
    if (advance && active) begin
      out_is_check <= cur.is_check;
      out_byte <= cur.is_check ? 8'h00 : cur_byte;
      out_last <= finishing;
      out_ok <= cur.is_check && cur.ok;
      out_reading <= cur.is_check ? cur.register_value : 16'h0000;
    end
  end

  assign res.valid = out_valid;
  assign res.is_check_result = out_is_check;
  assign res.send_byte = out_byte;
  assign res.last_of_frame = out_last;
  assign res.crc_ok = out_ok;
  assign res.reading = out_reading;

endmodule

FILE: src/modbus_rtu_frame_builder_checker.sv
// Modbus RTU request builder and reply checker with CRC-16/MODBUS.
// The cmd channel takes one beat per command. A send command (command 0) yields
// eight beats on the res channel: address, function, register high and low,
// value high and low, then the two CRC bytes, the last beat marked last_of_frame.
// A reply command (command 1) takes one received byte; the eighth byte of a
// reply yields one check beat with crc_ok and the reading from bytes 4 and 5.
// A send command also drops any partly received reply.
// cfg_write with cfg_data sets the CRC byte order (1 puts the low byte first).
// A command's first beat comes from the queue via the entry and output registers.
// Reply bytes are taken one per cycle while the queue has room; a send command
// holds the result side for its eight bytes, as its CRC is folded in as the bytes
// go out, one per cycle while the receiver is ready. A two-entry queue parts the
// command side from the result side, so commands keep flowing while results wait.
// When the receiver stalls, the output register holds its beat, the queue fills,
// and then cmd.ready falls. Reset empties the queue and the output register,
// restarts reply reception and sets the high-byte-first CRC order.
module modbus_rtu_frame_builder_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  mrfb_cmd_if.sink cmd,
  mrfb_res_if.source res
);

  logic crc_low_byte_first;
  logic q_full;
  logic q_pop;
  mrfb_pkg::queue_port_t q_push;
  mrfb_pkg::queue_port_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_low_byte_first <= 1'b0;
    end else if (cfg_write) begin
      crc_low_byte_first <= cfg_data;
    end
  end

  mrfb_front u_front (
    .clk(clk),
    .rst(rst),
    .low_first(crc_low_byte_first),
    .cmd(cmd),
    .full(q_full),
    .push(q_push)
  );

  mrfb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .full(q_full),
    .head(q_head),
    .pop(q_pop)
  );

  mrfb_back u_back (
    .clk(clk),
    .rst(rst),
    .low_first(crc_low_byte_first),
    .head(q_head),
    .pop(q_pop),
    .res(res)
  );

`ifndef SYNTH
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !cmd.ready)
    else $error("Command accepted while the queue is full.");

  a_check_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.is_check_result |-> res.last_of_frame && res.send_byte == 8'h00)
    else $error("Check beat is malformed.");

  a_send_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.is_check_result |-> !res.crc_ok && res.reading == 16'h0000)
    else $error("Transmit beat carries check fields.");

  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("Queue popped while empty.");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

typedef struct {
  logic command;
  logic [7:0] device_address;
  logic [7:0] function_number;
  logic [15:0] register_address;
  logic [15:0] register_value;
  logic [7:0] reply_byte;
} cmd_beat_t;

typedef struct {
  logic is_check_result;
  logic [7:0] send_byte;
  logic last_of_frame;
  logic crc_ok;
  logic [15:0] reading;
} res_beat_t;

class modbus_scoreboard;
  bit crc_low_first;
  bit [2:0] rx_count;
  bit [15:0] rx_crc;
  bit [7:0] rx_crc_first;
  bit [15:0] rx_reading;
  res_beat_t expected_q[$];
  int errors;

  function new();
    crc_low_first = 1'b0;
    rx_count = '0;
    rx_crc = mrfb_pkg::CRC_INIT;
    rx_crc_first = '0;
    rx_reading = '0;
    errors = 0;
  endfunction

  static function bit [15:0] crc16_byte(bit [15:0] acc, bit [7:0] b);
    bit [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) begin
      if (c[0]) c = (c >> 1) ^ mrfb_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function void set_order(bit low_first);
    crc_low_first = low_first;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void expect_beat(bit chk, bit [7:0] b, bit last, bit ok, bit [15:0] rd);
    res_beat_t r;
    r.is_check_result = chk;
    r.send_byte = b;
    r.last_of_frame = last;
    r.crc_ok = ok;
    r.reading = rd;
    expected_q.push_back(r);
  endfunction

  function void note_command(cmd_beat_t c);
    bit [7:0] frame [8];
    bit [15:0] crc;
    bit [7:0] want_first;
    bit [7:0] want_second;
    if (c.command == mrfb_pkg::CMD_SEND) begin
      frame[0] = c.device_address;
      frame[1] = c.function_number;
      frame[2] = c.register_address[15:8];
      frame[3] = c.register_address[7:0];
      frame[4] = c.register_value[15:8];
      frame[5] = c.register_value[7:0];
      crc = mrfb_pkg::CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc16_byte(crc, frame[i]);
      frame[6] = crc_low_first ? crc[7:0] : crc[15:8];
      frame[7] = crc_low_first ? crc[15:8] : crc[7:0];
      for (int i = 0; i < 8; i++) expect_beat(1'b0, frame[i], i == 7, 1'b0, 16'h0000);
      rx_count = '0;
      rx_crc = mrfb_pkg::CRC_INIT;
    end else if (rx_count < 3'd6) begin
      rx_crc = crc16_byte(rx_crc, c.reply_byte);
      if (rx_count == 3'd4) rx_reading[15:8] = c.reply_byte;
      if (rx_count == 3'd5) rx_reading[7:0] = c.reply_byte;
      rx_count++;
    end else if (rx_count == 3'd6) begin
      rx_crc_first = c.reply_byte;
      rx_count = 3'd7;
    end else begin
      want_first = crc_low_first ? rx_crc[7:0] : rx_crc[15:8];
      want_second = crc_low_first ? rx_crc[15:8] : rx_crc[7:0];
      expect_beat(1'b1, 8'h00, 1'b1,
                  (rx_crc_first == want_first) && (c.reply_byte == want_second), rx_reading);
      rx_count = '0;
      rx_crc = mrfb_pkg::CRC_INIT;
    end
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= 40) $display("mismatch in %s: got %h, expected %h", what, got, want);
  endtask

  task check_result(res_beat_t r);
    res_beat_t w;
    if (expected_q.size() == 0) begin
      report("unexpected beat, send_byte", 16'(r.send_byte), 16'h0000);
    end else begin
      w = expected_q.pop_front();
      if (r.is_check_result !== w.is_check_result)
        report("is_check_result", 16'(r.is_check_result), 16'(w.is_check_result));
      if (r.send_byte !== w.send_byte)
        report("send_byte", 16'(r.send_byte), 16'(w.send_byte));
      if (r.last_of_frame !== w.last_of_frame)
        report("last_of_frame", 16'(r.last_of_frame), 16'(w.last_of_frame));
      if (r.crc_ok !== w.crc_ok) report("crc_ok", 16'(r.crc_ok), 16'(w.crc_ok));
      if (r.reading !== w.reading) report("reading", r.reading, w.reading);
    end
  endtask
endclass

module tb;
  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;
  bit steady;
  int beats_sent;
  modbus_scoreboard board = new();

  mrfb_cmd_if cmd();
  mrfb_res_if res();

  modbus_rtu_frame_builder_checker i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  function automatic cmd_beat_t send_cmd(bit [7:0] dev, bit [7:0] fn, bit [15:0] addr,
                                         bit [15:0] val);
    cmd_beat_t c;
    c.command = mrfb_pkg::CMD_SEND;
    c.device_address = dev;
    c.function_number = fn;
    c.register_address = addr;
    c.register_value = val;
    c.reply_byte = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic cmd_beat_t reply_cmd(bit [7:0] b);
    cmd_beat_t c;
    c.command = mrfb_pkg::CMD_REPLY;
    c.device_address = 8'($urandom_range(255));
    c.function_number = 8'($urandom_range(255));
    c.register_address = 16'($urandom_range(65535));
    c.register_value = 16'($urandom_range(65535));
    c.reply_byte = b;
    return c;
  endfunction

  task automatic push(input cmd_beat_t c);
    while (!steady && $urandom_range(99) < 38) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.command = c.command;
    cmd.device_address = c.device_address;
    cmd.function_number = c.function_number;
    cmd.register_address = c.register_address;
    cmd.register_value = c.register_value;
    cmd.reply_byte = c.reply_byte;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    board.note_command(c);
    beats_sent++;
    @(negedge clk);
  endtask

  // A corrupt index of 64 or more leaves the frame intact.
  task automatic push_reply(input bit [47:0] body, input int corrupt, input bit swap);
    bit [15:0] crc;
    bit [63:0] frame;
    bit low_first;
    crc = mrfb_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) crc = board.crc16_byte(crc, body[47 - 8*i -: 8]);
    low_first = board.crc_low_first ^ swap;
    frame = {body, low_first ? {crc[7:0], crc[15:8]} : crc};
    if (corrupt < 64) frame[corrupt] = ~frame[corrupt];
    for (int i = 0; i < 8; i++) push(reply_cmd(frame[63 - 8*i -: 8]));
  endtask

  task automatic push_partial(input int n);
    for (int i = 0; i < n; i++) push(reply_cmd(8'($urandom_range(255))));
    push(send_cmd(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535))));
  endtask

  task automatic write_order(input bit low_first);
    cmd.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = low_first;
    @(negedge clk);
    cfg_write = 1'b0;
    board.set_order(low_first);
  endtask

  initial begin
    res.ready = 1'b0;
    forever begin
      res_beat_t r;
      @(posedge clk);
      if (!rst && res.valid === 1'b1 && res.ready) begin
        r.is_check_result = res.is_check_result;
        r.send_byte = res.send_byte;
        r.last_of_frame = res.last_of_frame;
        r.crc_ok = res.crc_ok;
        r.reading = res.reading;
        board.check_result(r);
      end
      @(negedge clk);
      res.ready = steady || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    int kind;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    steady = 1'b0;
    beats_sent = 0;
    cmd.valid = 1'b0;
    cmd.command = mrfb_pkg::CMD_SEND;
    cmd.device_address = '0;
    cmd.function_number = '0;
    cmd.register_address = '0;
    cmd.register_value = '0;
    cmd.reply_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push(send_cmd(8'h00, 8'h00, 16'h0000, 16'h0000));
    push(send_cmd(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    push(send_cmd(8'h01, 8'h03, 16'hA55A, 16'h5AA5));
    push_reply(48'hFFFF_FFFF_FFFF, 64, 1'b0);
    push_reply(48'h0000_0000_0000, 3, 1'b0);
    push_partial(3);
    write_order(1'b1);
    push_reply(48'h0103_0200_2A00, 64, 1'b0);
    push_reply(48'h0103_0200_2A00, 64, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      write_order(phase % 2 == 0);
      steady = (phase == 2);
      while (beats_sent < 60 + 60 * (phase + 1)) begin
        kind = $urandom_range(99);
        if (kind < 30)
          push(send_cmd(8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535))));
        else if (kind < 65)
          push_reply({$urandom, 16'($urandom_range(65535))}, 64, 1'b0);
        else if (kind < 78)
          push_reply({$urandom, 16'($urandom_range(65535))}, int'($urandom_range(63)),
                     1'b0);
        else if (kind < 84)
          push_reply({$urandom, 16'($urandom_range(65535))}, 64, 1'b1);
        else if (kind < 92)
          push_partial(int'($urandom_range(7, 1)));
        else
          push(reply_cmd(8'($urandom_range(255))));
      end
    end
    steady = 1'b0;

    cmd.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
